/* design/lpm_pkg.sv */
// Shared types and constants for the longest-prefix-match route forwarder.
// Holds the route entry layout, status and opcode codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package lpm_pkg;

    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 6;
    localparam int IFACE_W  = 3;
    localparam int TTL_W    = 8;
    localparam int STATUS_W = 3;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_FWD = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED        = 3'd0,
        ST_REJECTED     = 3'd1,
        ST_FORWARDED    = 3'd2,
        ST_DROP_TTL     = 3'd3,
        ST_DROP_NOROUTE = 3'd4,
        ST_DROP_BOUNCE  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FWD_SCAN,
        S_ADD_SHIFT,
        S_ADD_HEAD
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]  prefix;
        logic [LEN_W-1:0]   len;
        logic               has_gw;
        logic [ADDR_W-1:0]  gw;
        logic [IFACE_W-1:0] iface;
    } t_route;

endpackage

/* design/lpm_route_forwarder.sv */
// Top level of the longest-prefix-match route forwarder: route table memory,
// scan and insert sequencer, and registered result port.
// Depends on lpm_pkg.
//
// Channel   Handshake                    Ports
// -------   ---------------------------  -----------------------------------------
// command   start high while busy low    i_opcode, i_prefix, i_prefix_len,
//                                        i_has_gateway, i_gateway_addr,
//                                        i_route_iface, i_dst, i_ttl, i_arrival_iface
// result    o_done high for one cycle    o_status, o_out_iface, o_hop_addr, o_new_ttl
//
// A forward walks the table from the longest prefix down, one entry per cycle through
// the single registered read port, holding busy until a match or the last entry. An add
// walks from the tail, moving one shorter entry up per cycle through the single write
// port. Rejected adds, TTL drops, and adds or forwards into an empty table do not raise
// busy. The result appears on the cycle after the last busy cycle. Reset empties the
// table by clearing the route count; the receiver cannot stall the result.
`timescale 1ns / 1ps

module lpm_route_forwarder
    import lpm_pkg::*;
#(
    parameter int MAX_ROUTES = 32,
    parameter int NUM_IFACES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_opcode,
    input  logic [ADDR_W-1:0]   i_prefix,
    input  logic [LEN_W-1:0]    i_prefix_len,
    input  logic                i_has_gateway,
    input  logic [ADDR_W-1:0]   i_gateway_addr,
    input  logic [IFACE_W-1:0]  i_route_iface,
    input  logic [ADDR_W-1:0]   i_dst,
    input  logic [TTL_W-1:0]    i_ttl,
    input  logic [IFACE_W-1:0]  i_arrival_iface,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [IFACE_W-1:0]  o_out_iface,
    output logic [ADDR_W-1:0]   o_hop_addr,
    output logic [TTL_W-1:0]    o_new_ttl
);

    localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CNT_W = $clog2(MAX_ROUTES + 1);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_ptr, n_ptr;

    t_route              r_new_route;
    logic [ADDR_W-1:0]   r_dst;
    logic [TTL_W-1:0]    r_ttl;
    logic [IFACE_W-1:0]  r_arr;

    t_route              r_mem [MAX_ROUTES];
    t_route              r_rd_data;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    t_route              wr_data;

    logic                r_done, n_done;
    t_status             r_status, n_status;
    logic [IFACE_W-1:0]  r_out_iface, n_out_iface;
    logic [ADDR_W-1:0]   r_hop_addr, n_hop_addr;
    logic [TTL_W-1:0]    r_new_ttl, n_new_ttl;

    logic                accept;
    logic                add_reject;
    t_route              in_route;
    logic [ADDR_W-1:0]   match_mask;
    logic                entry_match;
    logic                entry_bounce;
    logic                scan_last;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    assign in_route.prefix = i_prefix;
    assign in_route.len    = i_prefix_len;
    assign in_route.has_gw = i_has_gateway;
    assign in_route.gw     = i_gateway_addr;
    assign in_route.iface  = i_route_iface;

    assign add_reject = (i_prefix_len > LEN_W'(ADDR_W))
                     || (r_count == CNT_W'(MAX_ROUTES))
                     || (32'(i_route_iface) >= NUM_IFACES);

    assign match_mask   = ~({ADDR_W{1'b1}} >> r_rd_data.len);
    assign entry_match  = ((r_dst ^ r_rd_data.prefix) & match_mask) == '0;
    assign entry_bounce = r_rd_data.has_gw && (r_rd_data.iface == r_arr);
    assign scan_last    = (CNT_W'(r_ptr) + CNT_W'(1)) == r_count;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_new_route <= in_route;
            r_dst       <= i_dst;
            r_ttl       <= i_ttl;
            r_arr       <= i_arrival_iface;
        end
        r_ptr       <= n_ptr;
        r_status    <= n_status;
        r_out_iface <= n_out_iface;
        r_hop_addr  <= n_hop_addr;
        r_new_ttl   <= n_new_ttl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_done      = 1'b0;
        n_status    = r_status;
        n_out_iface = '0;
        n_hop_addr  = '0;
        n_new_ttl   = '0;
        rd_addr     = r_ptr;
        wr_en       = 1'b0;
        wr_addr     = r_ptr;
        wr_data     = r_new_route;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_FWD) begin
                        if (i_ttl <= TTL_W'(1)) begin
                            n_done   = 1'b1;
                            n_status = ST_DROP_TTL;
                        end else if (r_count == '0) begin
                            n_done   = 1'b1;
                            n_status = ST_DROP_NOROUTE;
                        end else begin
                            rd_addr = '0;
                            n_ptr   = '0;
                            n_state = S_FWD_SCAN;
                        end
                    end else begin
                        if (add_reject) begin
                            n_done   = 1'b1;
                            n_status = ST_REJECTED;
                        end else if (r_count == '0) begin
                            wr_en    = 1'b1;
                            wr_addr  = '0;
                            wr_data  = in_route;
                            n_count  = CNT_W'(r_count + 1'b1);
                            n_done   = 1'b1;
                            n_status = ST_ADDED;
                        end else begin
                            rd_addr = IDX_W'(r_count - 1'b1);
                            n_ptr   = IDX_W'(r_count - 1'b1);
                            n_state = S_ADD_SHIFT;
                        end
                    end
                end
            end
            S_FWD_SCAN: begin
                if (entry_match) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (entry_bounce) begin
                        n_status = ST_DROP_BOUNCE;
                    end else begin
                        n_status    = ST_FORWARDED;
                        n_out_iface = r_rd_data.iface;
                        n_hop_addr  = r_rd_data.has_gw ? r_rd_data.gw : r_dst;
                        n_new_ttl   = TTL_W'(r_ttl - 1'b1);
                    end
                end else if (scan_last) begin
                    n_done   = 1'b1;
                    n_status = ST_DROP_NOROUTE;
                    n_state  = S_IDLE;
                end else begin
                    rd_addr = IDX_W'(r_ptr + 1'b1);
                    n_ptr   = IDX_W'(r_ptr + 1'b1);
                end
            end
            S_ADD_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(r_ptr + 1'b1);
                if (r_rd_data.len >= r_new_route.len) begin
                    wr_data  = r_new_route;
                    n_count  = CNT_W'(r_count + 1'b1);
                    n_done   = 1'b1;
                    n_status = ST_ADDED;
                    n_state  = S_IDLE;
                end else begin
                    wr_data = r_rd_data;
                    if (r_ptr == '0) begin
                        n_state = S_ADD_HEAD;
                    end else begin
                        rd_addr = IDX_W'(r_ptr - 1'b1);
                        n_ptr   = IDX_W'(r_ptr - 1'b1);
                    end
                end
            end
            S_ADD_HEAD: begin
                wr_en    = 1'b1;
                wr_addr  = '0;
                wr_data  = r_new_route;
                n_count  = CNT_W'(r_count + 1'b1);
                n_done   = 1'b1;
                n_status = ST_ADDED;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_out_iface = r_out_iface;
    assign o_hop_addr  = r_hop_addr;
    assign o_new_ttl   = r_new_ttl;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_ROUTES)
        else $error("route count exceeds table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == CNT_W'($past(r_count) + 1'b1) && o_done && o_status == ST_ADDED))
        else $error("route count changed without an added result");

    a_ttl_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OP_FWD && i_ttl <= TTL_W'(1)) |=>
            (o_done && o_status == ST_DROP_TTL))
        else $error("expiring datagram not dropped on the next cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$past(busy) || (r_state == S_IDLE))
        else $error("result strobe while the sequencer is still scanning");
`endif

endmodule
